@@ sv/mat4_vector_transform_top_assert.svh @@
// assertion macros for the matrix-vector transform block
`ifndef MAT4_VECTOR_TRANSFORM_TOP_ASSERT_SVH
`define MAT4_VECTOR_TRANSFORM_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MVT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MVT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that is also checked while reset is high
`define MVT_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/mvt_pkg.sv @@
`default_nettype none

package mvt_pkg;

  localparam int COEF_W              = 16;
  localparam int COEF_FRAC           = 12;
  localparam int NUM_COLS            = 4;
  localparam int CFG_W               = 64;
  localparam int CFG_INDEX_W         = 8;
  localparam int COMPONENT_WIDTH_DEF = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN0 = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN1 = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN2 = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN3 = 8'd3;

  // identity matrix after reset
  localparam logic [CFG_W-1:0] COLUMN0_RST = 64'h0000_0000_0000_1000;
  localparam logic [CFG_W-1:0] COLUMN1_RST = 64'h0000_0000_1000_0000;
  localparam logic [CFG_W-1:0] COLUMN2_RST = 64'h0000_1000_0000_0000;
  localparam logic [CFG_W-1:0] COLUMN3_RST = 64'h1000_0000_0000_0000;

  // pipeline load strobes shared by all lanes
  typedef struct packed {
    logic prod_load;
    logic sum_load;
  } stage_ctrl_t;

endpackage

`default_nettype wire

@@ sv/mat4_vector_transform_top.sv @@
`default_nettype none

// 4x4 fixed-point matrix times vector. Each input word carries one vertex
// (vx, vy, vz, vw); each output word carries the transformed vertex, every
// component being the sum of M[r][c]*v[c] with Q4.12 coefficients, rounded to
// nearest (ties toward plus infinity) and saturated to COMPONENT_WIDTH bits,
// plus a clipped flag in tuser when any component saturated. The matrix sits
// in four 64-bit column registers (column3 is the translation) that reset to
// the identity; write them only while no vertex is in flight. Throughput is
// one vertex per clock while m_tready stays high. Four row lanes each
// register their products, then their rounded sum, and a merge register
// holds the output word. Each stage has its own valid bit, so bubbles
// close up under back-pressure and the block keeps taking words while a
// finished word waits, until the product and sum stages are full as well.
// For vec3 or vec2 use, drive vw, or vz and vw, with 0.
module mat4_vector_transform_top #(
  parameter int COMPONENT_WIDTH = mvt_pkg::COMPONENT_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  // configuration write port
  input  wire                                cfg_we,
  input  wire  [mvt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [mvt_pkg::CFG_W-1:0]          cfg_data,
  // input stream
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,  // vx, vy, vz, vw, zero pad
  // output stream
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] m_tdata,  // ox, oy, oz, ow, zero pad
  output logic                               m_tuser   // clipped
);

  `include "mat4_vector_transform_top_assert.svh"

  localparam int NC     = mvt_pkg::NUM_COLS;
  localparam int CW     = mvt_pkg::COEF_W;
  localparam int DATA_W = ((4*COMPONENT_WIDTH+7)/8)*8;

  // matrix columns, each holding four Q4.12 row elements
  logic [mvt_pkg::CFG_W-1:0] column [NC];

  // per-stage valid bits
  logic prod_v;
  logic sum_v;
  logic out_v;

  // stage readiness, back to front
  logic out_ready;
  logic sum_ready;
  logic prod_ready;

  mvt_pkg::stage_ctrl_t ctrl;

  logic signed [COMPONENT_WIDTH-1:0] vin   [NC];
  logic signed [COMPONENT_WIDTH-1:0] y     [NC];
  logic [NC-1:0]                     clip;

  // config writes; out-of-range indexes fall into the default arm
  always_ff @(posedge clk) begin
    if (rst) begin
      column[0] <= mvt_pkg::COLUMN0_RST;
      column[1] <= mvt_pkg::COLUMN1_RST;
      column[2] <= mvt_pkg::COLUMN2_RST;
      column[3] <= mvt_pkg::COLUMN3_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mvt_pkg::REG_COLUMN0: column[0] <= cfg_data;
        mvt_pkg::REG_COLUMN1: column[1] <= cfg_data;
        mvt_pkg::REG_COLUMN2: column[2] <= cfg_data;
        mvt_pkg::REG_COLUMN3: column[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage can take a word when empty or when its word moves on
  assign out_ready  = !out_v  || m_tready;
  assign sum_ready  = !sum_v  || out_ready;
  assign prod_ready = !prod_v || sum_ready;
  assign s_tready   = prod_ready;

  assign ctrl = '{prod_load: prod_ready && s_tvalid, sum_load: sum_ready && prod_v};

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
      sum_v  <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_v <= s_tvalid;
      end
      if (sum_ready) begin
        sum_v <= prod_v;
      end
      if (out_ready) begin
        out_v <= sum_v;
      end
    end
  end

  assign m_tvalid = out_v;

  // unpack the vertex, x in the lowest bits
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      vin[c] = s_tdata[c*COMPONENT_WIDTH +: COMPONENT_WIDTH];
    end
  end

  // one lane per output row; lane r sees row r of every column
  for (genvar r = 0; r < NC; r++) begin : g_lane
    logic signed [CW-1:0] coef [NC];

    always_comb begin
      for (int c = 0; c < NC; c++) begin
        coef[c] = column[c][r*CW +: CW];
      end
    end

    mvt_lane #(
      .COMPONENT_WIDTH(COMPONENT_WIDTH)
    ) u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .coef (coef),
      .v    (vin),
      .y    (y[r]),
      .clip (clip[r])
    );
  end

  mvt_merge #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH),
    .DATA_W         (DATA_W)
  ) u_merge (
    .clk     (clk),
    .load    (out_ready && sum_v),
    .y       (y),
    .clip    (clip),
    .data    (m_tdata),
    .clipped (m_tuser)
  );

  // an empty output register never blocks the input
  `MVT_ASSERT_IMP(a_ready_when_empty, clk, rst, !out_v, s_tready, "input blocked with output empty")
  // a stalled sum stage keeps its word
  `MVT_ASSERT_NXT(a_sum_hold, clk, rst, sum_v && !out_ready, sum_v, "sum stage word lost")
  // a stalled product stage keeps its word
  `MVT_ASSERT_NXT(a_prod_hold, clk, rst, prod_v && !sum_ready, prod_v, "product stage word lost")
  // the matrix comes out of reset as the identity
  `MVT_ASSERT_ALWAYS(a_reset_identity, clk, rst, (column[0] == mvt_pkg::COLUMN0_RST) && (column[3] == mvt_pkg::COLUMN3_RST), "matrix not identity after reset")

endmodule

`default_nettype wire

@@ sv/mvt_lane.sv @@
`default_nettype none

// one output row: four products, rounded sum, saturation
module mvt_lane #(
  parameter int COMPONENT_WIDTH = mvt_pkg::COMPONENT_WIDTH_DEF
) (
  input  wire                                    clk,
  input  wire  mvt_pkg::stage_ctrl_t             ctrl,
  input  wire  logic signed [mvt_pkg::COEF_W-1:0] coef [mvt_pkg::NUM_COLS],
  input  wire  logic signed [COMPONENT_WIDTH-1:0] v    [mvt_pkg::NUM_COLS],
  output logic signed [COMPONENT_WIDTH-1:0]       y,
  output logic                                    clip
);

  localparam int PROD_W = COMPONENT_WIDTH + mvt_pkg::COEF_W;
  localparam int ACC_W  = COMPONENT_WIDTH + 18;
  localparam int FRAC   = mvt_pkg::COEF_FRAC;
  localparam int HI_W   = ACC_W - FRAC - COMPONENT_WIDTH + 1;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC - 1);

  logic signed [PROD_W-1:0] prod [mvt_pkg::NUM_COLS];
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  sum_next;
  logic [HI_W-1:0]          hi;
  logic                     ovf;

  always_ff @(posedge clk) begin
    if (ctrl.prod_load) begin
      for (int c = 0; c < mvt_pkg::NUM_COLS; c++) begin
        prod[c] <= PROD_W'(coef[c]) * PROD_W'(v[c]);
      end
    end
  end

  always_comb begin
    sum_next = ROUND_HALF;
    for (int c = 0; c < mvt_pkg::NUM_COLS; c++) begin
      sum_next = sum_next + ACC_W'(prod[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_load) begin
      sum <= sum_next;
    end
  end

  // bits above the kept field must all equal the sign, else saturate
  assign hi   = sum[ACC_W-1 -: HI_W];
  assign ovf  = !((&hi) || !(|hi));
  assign clip = ovf;

  always_comb begin
    if (!ovf) begin
      y = sum[FRAC +: COMPONENT_WIDTH];
    end else if (sum[ACC_W-1]) begin
      y = {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};
    end else begin
      y = {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

@@ sv/mvt_merge.sv @@
`default_nettype none

// gathers the four lane results into the output word register
module mvt_merge #(
  parameter int COMPONENT_WIDTH = mvt_pkg::COMPONENT_WIDTH_DEF,
  parameter int DATA_W          = 64
) (
  input  wire                                      clk,
  input  wire                                      load,
  input  wire  logic signed [COMPONENT_WIDTH-1:0]   y    [mvt_pkg::NUM_COLS],
  input  wire  logic [mvt_pkg::NUM_COLS-1:0]        clip,
  output logic [DATA_W-1:0]                         data,
  output logic                                      clipped
);

  logic [DATA_W-1:0] data_next;

  always_comb begin
    data_next = '0;
    for (int r = 0; r < mvt_pkg::NUM_COLS; r++) begin
      data_next[r*COMPONENT_WIDTH +: COMPONENT_WIDTH] = y[r];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data    <= data_next;
      clipped <= |clip;
    end
  end

endmodule

`default_nettype wire

@@ tb/mvt_checker.sv @@
module mvt_checker import mvt_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [CFG_INDEX_W-1:0]                 cfg_index,
  input  logic [CFG_W-1:0]                       cfg_data,
  input  logic                                   s_tvalid,
  input  logic                                   s_tready,
  input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic                                   m_tvalid,
  input  logic                                   m_tready,
  input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] m_tdata,
  input  logic                                   m_tuser,
  output int                                     errors,
  output int                                     outstanding,
  output int                                     checked,
  output int                                     clipped_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     WORD_W   = ((4*COMPONENT_WIDTH+7)/8)*8;
  localparam longint COMP_MAX = (longint'(1) << (COMPONENT_WIDTH-1)) - 1;
  localparam longint COMP_MIN = -COMP_MAX - 1;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic              clipped;
  } vertex_result_t;

  // shadow copy of the four column registers
  logic [CFG_W-1:0] columns [NUM_COLS];
  vertex_result_t   transformed_q [$];

  function automatic vertex_result_t transform_vertex(input logic [WORD_W-1:0] word);
    vertex_result_t res;
    longint         acc;
    longint         y;
    res = '0;
    for (int r = 0; r < NUM_COLS; r++) begin
      acc = 0;
      for (int c = 0; c < NUM_COLS; c++) begin
        acc += longint'($signed(columns[c][COEF_W*r +: COEF_W])) *
               longint'($signed(word[COMPONENT_WIDTH*c +: COMPONENT_WIDTH]));
      end
      // round half up, then floor shift back to the input scale
      y = (acc + (longint'(1) << (COEF_FRAC-1))) >>> COEF_FRAC;
      if (y > COMP_MAX) begin
        y = COMP_MAX;
        res.clipped = 1'b1;
      end else if (y < COMP_MIN) begin
        y = COMP_MIN;
        res.clipped = 1'b1;
      end
      res.data[COMPONENT_WIDTH*r +: COMPONENT_WIDTH] = y[COMPONENT_WIDTH-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    vertex_result_t             want;
    logic [COMPONENT_WIDTH-1:0] got_c;
    logic [COMPONENT_WIDTH-1:0] want_c;
    if (rst) begin
      columns[0] = COLUMN0_RST;
      columns[1] = COLUMN1_RST;
      columns[2] = COLUMN2_RST;
      columns[3] = COLUMN3_RST;
      transformed_q.delete();
    end else begin
      if (cfg_we && cfg_index < NUM_COLS) begin
        columns[cfg_index[1:0]] = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        if (transformed_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output word %h clipped %b", $time, m_tdata, m_tuser);
        end else begin
          want = transformed_q.pop_front();
          for (int r = 0; r < NUM_COLS; r++) begin
            got_c  = m_tdata[COMPONENT_WIDTH*r +: COMPONENT_WIDTH];
            want_c = want.data[COMPONENT_WIDTH*r +: COMPONENT_WIDTH];
            if (got_c !== want_c) begin
              errors++;
              $display("%0t: vertex %0d component %0d expected %h actual %h",
                       $time, checked, r, want_c, got_c);
            end
          end
          if (m_tuser !== want.clipped) begin
            errors++;
            $display("%0t: vertex %0d clipped expected %b actual %b",
                     $time, checked, want.clipped, m_tuser);
          end
          if (m_tuser === 1'b1) clipped_seen++;
          checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        transformed_q.push_back(transform_vertex(s_tdata));
      end
    end
    outstanding = transformed_q.size();
  end

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mvt_pkg::*;

  localparam int COMPONENT_WIDTH = 16;
  localparam int WORD_W          = ((4*COMPONENT_WIDTH+7)/8)*8;
  localparam int PIPE_LATENCY    = 3;     // input accepted to output able to leave
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
  localparam int STALL_LIMIT     = 4000;  // cycles with no word moving
  localparam int PHASE_WORDS     = 231;
  localparam int NUM_PHASES      = 8;

  // writes to these land outside the register file and must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_PAST_END = CFG_INDEX_W'(NUM_COLS);
  localparam logic [CFG_INDEX_W-1:0] REG_TOP      = '1;
  localparam logic [NUM_COLS-1:0][CFG_INDEX_W-1:0] COLUMN_REGS =
    {REG_COLUMN3, REG_COLUMN2, REG_COLUMN1, REG_COLUMN0};

  typedef enum {MX_RANDOM, MX_ZERO, MX_ONES, MX_SMALL, MX_MAXPOS, MX_MAXNEG} matrix_kind_t;
  typedef logic [NUM_COLS-1:0][CFG_W-1:0] matrix_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic [WORD_W-1:0]      s_tdata   = '0;
  logic                   m_tready  = 1'b0;
  wire                    s_tready;
  wire                    m_tvalid;
  wire  [WORD_W-1:0]      m_tdata;
  wire                    m_tuser;

  int  errors, outstanding, checked, clipped_seen;
  int  words_sent;
  int  settings_loaded;
  int  idle_cycles;
  bit  hold_req;     // stimulus asks the receiver for a long hold-off
  bit  hold_active;  // receiver is in the hold-off
  bit  quiet;        // stretch with no idling on either side

  matrix_kind_t phase_plan [NUM_PHASES] =
    '{MX_RANDOM, MX_ZERO, MX_SMALL, MX_ONES, MX_RANDOM, MX_MAXPOS, MX_MAXNEG, MX_SMALL};

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mat4_vector_transform_top #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // vx, vy, vz, vw
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // ox, oy, oz, ow
    .m_tuser  (m_tuser)    // clipped
  );

  // watches both streams and the register port, predicts every vertex
  mvt_checker #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) vertex_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked),
    .clipped_seen(clipped_seen)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet)     return 0;
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // extremes, small values around zero, or any value
  function automatic logic [COMPONENT_WIDTH-1:0] random_component();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
      1:       return {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};
      2:       return '0;
      3, 4:    return COMPONENT_WIDTH'($urandom_range(0, 511) - 256);
      default: return COMPONENT_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pack_vertex(
    input logic [COMPONENT_WIDTH-1:0] x, y, z, w
  );
    logic [WORD_W-1:0] word;
    word = '0;
    word[0*COMPONENT_WIDTH +: COMPONENT_WIDTH] = x;
    word[1*COMPONENT_WIDTH +: COMPONENT_WIDTH] = y;
    word[2*COMPONENT_WIDTH +: COMPONENT_WIDTH] = z;
    word[3*COMPONENT_WIDTH +: COMPONENT_WIDTH] = w;
    return word;
  endfunction

  // full vertices, with some vec3 and vec2 forms mixed in
  function automatic logic [WORD_W-1:0] random_vertex();
    logic [COMPONENT_WIDTH-1:0] x, y, z, w;
    int form;
    x    = random_component();
    y    = random_component();
    z    = random_component();
    w    = random_component();
    form = $urandom_range(0, 9);
    if (form == 0) begin
      z = '0;
      w = '0;
    end else if (form == 1) begin
      w = '0;
    end
    return pack_vertex(x, y, z, w);
  endfunction

  function automatic logic [COEF_W-1:0] random_coef(input matrix_kind_t kind);
    case (kind)
      MX_ZERO:   return '0;
      MX_ONES:   return '1;
      MX_MAXPOS: return 16'h7fff;
      MX_MAXNEG: return 16'h8000;
      MX_SMALL:  return COEF_W'($urandom_range(0, 8192) - 4096);  // within +-1.0
      default: begin
        case ($urandom_range(0, 5))
          0:       return 16'h7fff;
          1:       return 16'h8000;
          2:       return 16'h1000;
          3:       return '0;
          default: return COEF_W'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic matrix_t random_matrix(input matrix_kind_t kind);
    matrix_t m;
    for (int c = 0; c < NUM_COLS; c++) begin
      for (int r = 0; r < NUM_COLS; r++) begin
        m[c][COEF_W*r +: COEF_W] = random_coef(kind);
      end
    end
    return m;
  endfunction

  // starts and ends just after a falling edge
  task automatic send_vertex(input logic [WORD_W-1:0] word);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // stop sending and wait until every vertex has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  // only called while the pipeline is empty
  task automatic load_matrix(input matrix_t m);
    for (int c = 0; c < NUM_COLS; c++) begin
      cfg_we    <= 1'b1;
      cfg_index <= COLUMN_REGS[c];
      cfg_data  <= m[c];
      @(negedge clk);
    end
    // out-of-range indexes must leave the matrix alone
    cfg_index <= REG_PAST_END;
    cfg_data  <= {$urandom, $urandom};
    @(negedge clk);
    cfg_index <= REG_TOP;
    cfg_data  <= {$urandom, $urandom};
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic run_phase(input matrix_kind_t kind, input bit with_hold);
    load_matrix(random_matrix(kind));
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (with_hold && i == 90) begin
        // back-to-back burst into a stopped receiver fills the pipe
        s_tvalid <= 1'b0;
        hold_req = 1'b1;
        quiet    = 1'b1;
        do @(negedge clk); while (!hold_active);
      end
      send_vertex(random_vertex());
    end
    drain();
  endtask

  // receiver: random ready runs and stalls, plus the long hold-off on request
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready   <= 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req    = 1'b0;
        hold_active = 1'b0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (1 + idle_gap()) @(negedge clk);
      end
    end
  end

  // watchdog: ends the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d vertices outstanding",
               $time, STALL_LIMIT, outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity after reset: outputs equal inputs, extremes pass unclipped
    send_vertex(pack_vertex(0, 0, 0, 0));
    send_vertex(pack_vertex(32767, 32767, 32767, 32767));
    send_vertex(pack_vertex(-32768, -32768, -32768, -32768));
    send_vertex(pack_vertex(32767, -32768, 1, -1));
    send_vertex(pack_vertex(16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0));
    send_vertex(pack_vertex(100, -200, 300, 0));   // vec3 form
    send_vertex(pack_vertex(7, -9, 0, 0));         // vec2 form
    drain();

    // rounding: x column holds +0.5, -0.5 and +-1 lsb, ties go toward +inf
    load_matrix({64'h0, 64'h0, 64'h0, 64'hffff_0001_f800_0800});
    send_vertex(pack_vertex(1, 0, 0, 0));
    send_vertex(pack_vertex(-1, 0, 0, 0));
    send_vertex(pack_vertex(3, 0, 0, 0));
    send_vertex(pack_vertex(-3, 0, 0, 0));
    send_vertex(pack_vertex(2048, 0, 0, 0));
    send_vertex(pack_vertex(-2048, 0, 0, 0));
    send_vertex(pack_vertex(32767, 0, 0, 0));
    send_vertex(pack_vertex(-32768, 0, 0, 0));
    drain();

    // saturation both ways with the largest coefficients
    load_matrix({NUM_COLS{64'h7fff_7fff_7fff_7fff}});
    send_vertex(pack_vertex(32767, 32767, 32767, 32767));
    send_vertex(pack_vertex(-32768, -32768, -32768, -32768));
    drain();
    load_matrix({NUM_COLS{64'h8000_8000_8000_8000}});
    send_vertex(pack_vertex(-32768, -32768, -32768, -32768));
    send_vertex(pack_vertex(32767, 32767, 32767, 32767));
    drain();

    // random vertices under a series of matrices, one with the long hold-off
    for (int p = 0; p < NUM_PHASES; p++) begin
      run_phase(phase_plan[p], p == 2);
    end

    repeat (4 * PIPE_LATENCY) @(negedge clk);
    $display("covered %0d vertices under %0d matrix settings, %0d results compared",
             words_sent, settings_loaded, checked);
    $display("%0d results saturated, one receiver hold-off of %0d cycles",
             clipped_seen, HOLD_CYCLES);
    if (errors == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/mvt_pkg.sv
sv/mvt_lane.sv
sv/mvt_merge.sv
sv/mat4_vector_transform_top.sv
tb/mvt_checker.sv
tb/tb.sv
